// ===== rtl/core/mat_pkg.sv =====
package mat_pkg;

    localparam int WINDOW    = 10;
    localparam int SAMPLE_W  = 12;
    localparam int TEMP_W    = 12;
    localparam int SCALE     = 3300;
    localparam int FS_SHIFT  = 12;

    localparam int SUM_W     = $clog2(WINDOW * 4095 + 1);
    localparam int Q_W       = $clog2(SCALE * WINDOW + 1);
    localparam int DIV_L     = $clog2(WINDOW);
    localparam int DIV_K     = Q_W + DIV_L;
    localparam int RECIP_W   = DIV_K + 1;
    localparam longint RECIP = ((64'd1 << DIV_K) + WINDOW - 1) / WINDOW;

    localparam int SCALE_W   = $clog2(SCALE + 1);
    localparam int P1_W      = SUM_W + SCALE_W;
    localparam int P2_W      = Q_W + RECIP_W;

    typedef enum logic [1:0] {
        BAND_BELOW  = 2'd0,
        BAND_WITHIN = 2'd1,
        BAND_ABOVE  = 2'd2
    } t_band;

    typedef enum logic {
        CFG_LOW  = 1'b0,
        CFG_HIGH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [TEMP_W-1:0] low;
        logic [TEMP_W-1:0] high;
    } t_limits;

endpackage

// ===== rtl/core/mat_if.sv =====
interface mat_in_if;
    logic                          valid;
    logic                          ready;
    logic [mat_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mat_out_if;
    logic                          valid;
    logic                          ready;
    logic [mat_pkg::TEMP_W-1:0]    temperature_tenths;
    logic [1:0]                    band;

    modport source (output valid, output temperature_tenths, output band, input ready);
    modport sink   (input valid, input temperature_tenths, input band, output ready);
endinterface

// ===== rtl/core/mat_cell.sv =====
module mat_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [mat_pkg::SAMPLE_W-1:0] i_sample,
    output logic [mat_pkg::SAMPLE_W-1:0] o_sample
);

    logic [mat_pkg::SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

// ===== rtl/core/mat_scaler.sv =====
module mat_scaler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mat_pkg::SUM_W-1:0] i_sum,
    input  mat_pkg::t_limits          i_limits,
    mat_out_if.source                 o_word
);

    logic                          r_v2, r_v3, r_v4;
    logic [mat_pkg::Q_W-1:0]       r_q;
    logic [mat_pkg::P2_W-1:0]      r_prod;
    logic [mat_pkg::TEMP_W-1:0]    r_temp;
    mat_pkg::t_band                r_band;

    logic                          en2, en3, en4;
    logic [mat_pkg::P1_W-1:0]      n_p1;
    logic [mat_pkg::P2_W-1:0]      n_prod;
    logic [mat_pkg::TEMP_W-1:0]    n_temp;
    mat_pkg::t_band                n_band;

    assign en4 = !r_v4 || o_word.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign o_ready = en2;

    assign n_p1   = mat_pkg::P1_W'(i_sum) * mat_pkg::P1_W'(mat_pkg::SCALE);
    assign n_prod = mat_pkg::P2_W'(r_q)
                  * mat_pkg::P2_W'(mat_pkg::RECIP_W'(mat_pkg::RECIP));
    assign n_temp = r_prod[mat_pkg::DIV_K + mat_pkg::TEMP_W - 1:mat_pkg::DIV_K];

    always_comb begin
        if (n_temp < i_limits.low) begin
            n_band = mat_pkg::BAND_BELOW;
        end else if (n_temp > i_limits.high) begin
            n_band = mat_pkg::BAND_ABOVE;
        end else begin
            n_band = mat_pkg::BAND_WITHIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) r_v2 <= i_valid;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) r_q    <= n_p1[mat_pkg::Q_W + mat_pkg::FS_SHIFT - 1:mat_pkg::FS_SHIFT];
        if (en3) r_prod <= n_prod;
        if (en4) begin
            r_temp <= n_temp;
            r_band <= n_band;
        end
    end

    assign o_word.valid              = r_v4;
    assign o_word.temperature_tenths = r_temp;
    assign o_word.band               = r_band;

endmodule

// ===== rtl/core/moving_average_temperature_band.sv =====
// channel        dir  payload                          width
// i_sample_chan  in   sample                           12
// o_result_chan  out  temperature_tenths, band         12, 2
// i_cfg_*        in   low/high threshold write         1 index, 12 data
//
// one word per cycle while the output is not stalled
// the result is registered after the sum stage, scale multiply, reciprocal multiply and band compare
// synchronous reset clears the sample cells and running sum, loads default thresholds
// a stalled output holds its word; earlier stages keep filling bubbles until full
module moving_average_temperature_band (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mat_in_if.sink                        i_sample_chan,
    mat_out_if.source                     o_result_chan,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [mat_pkg::TEMP_W-1:0]    i_cfg_data
);

    logic [mat_pkg::SAMPLE_W-1:0] w_tap [mat_pkg::WINDOW];
    logic [mat_pkg::SAMPLE_W-1:0] w_tap_in [mat_pkg::WINDOW];

    logic                         r_v1;
    logic [mat_pkg::SUM_W-1:0]    r_sum;
    mat_pkg::t_limits             r_limits;

    logic                         scaler_ready;
    logic                         accept;
    logic [mat_pkg::SUM_W-1:0]    n_sum;

    assign i_sample_chan.ready = !r_v1 || scaler_ready;
    assign accept = i_sample_chan.valid && i_sample_chan.ready;

    genvar k;
    generate
        for (k = 0; k < mat_pkg::WINDOW; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign w_tap_in[k] = i_sample_chan.sample;
            end else begin : g_link
                assign w_tap_in[k] = w_tap[k-1];
            end
            mat_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (accept),
                .i_sample (w_tap_in[k]),
                .o_sample (w_tap[k])
            );
        end
    endgenerate

    assign n_sum = r_sum - mat_pkg::SUM_W'(w_tap[mat_pkg::WINDOW-1])
                 + mat_pkg::SUM_W'(i_sample_chan.sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_sum         <= '0;
            r_limits.low  <= mat_pkg::TEMP_W'(310);
            r_limits.high <= mat_pkg::TEMP_W'(350);
        end else begin
            if (accept) begin
                r_v1  <= 1'b1;
                r_sum <= n_sum;
            end else if (scaler_ready) begin
                r_v1 <= 1'b0;
            end
            if (i_cfg_we) begin
                case (mat_pkg::t_cfg_idx'(i_cfg_idx))
                    mat_pkg::CFG_LOW:  r_limits.low  <= i_cfg_data;
                    mat_pkg::CFG_HIGH: r_limits.high <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    mat_scaler u_scaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .o_ready  (scaler_ready),
        .i_sum    (r_sum),
        .i_limits (r_limits),
        .o_word   (o_result_chan)
    );

`ifndef NO_ASSERTIONS
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted word did not reach the sum stage");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !scaler_ready) |-> !i_sample_chan.ready)
        else $error("input taken while sum stage is stalled");

    a_band_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_chan.valid |-> (o_result_chan.band != 2'd3))
        else $error("illegal band code");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_chan.valid |-> (o_result_chan.temperature_tenths < 12'd3300))
        else $error("temperature out of range");
`endif

endmodule
